// ===== rtl/sps_pkg.sv =====
package sps_pkg;

    // one full step in tenths of a degree
    localparam logic signed [16:0] STEP_TENTHS = 17'sd18;
    localparam logic [7:0]         LOW_NIBBLE  = 8'h0F;

    // configuration register indexes
    localparam logic [1:0] CFG_DEADTIME_ENABLE = 2'd0;
    localparam logic [1:0] CFG_STEP_DELAY      = 2'd1;
    localparam logic [1:0] CFG_DEADTIME_DELAY  = 2'd2;

    // request kinds on the input side
    localparam logic MODE_POLL   = 1'b0;
    localparam logic MODE_EXPIRY = 1'b1;

    // reported motion state codes
    localparam logic [1:0] STATE_CODE_IDLE = 2'd0;
    localparam logic [1:0] STATE_CODE_DEAD = 2'd1;
    localparam logic [1:0] STATE_CODE_STEP = 2'd2;

    localparam logic [15:0] DEADTIME_DELAY_RESET = 16'd4;

    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 48;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_DEAD = 3'b010,
        PH_STEP = 3'b100
    } motion_phase_t;

    typedef struct packed {
        logic        deadtime_enable;
        logic [15:0] step_delay;
        logic [15:0] deadtime_delay;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         phase_index;
        motion_phase_t      motion_phase;
        logic               turn_reverse;
        logic signed [15:0] shaft_angle;
        logic [7:0]         drive_latch;
    } motor_state_t;

    typedef struct packed {
        logic signed [15:0] angle_now;
        logic [1:0]         motion_state;
        logic [15:0]        delay_ticks;
        logic               delay_start;
        logic [7:0]         coil_drive;
    } result_t;

    // full-step drive pattern table
    function automatic logic [7:0] step_pattern(input logic [1:0] idx);
        logic [7:0] pat;
        case (idx)
            2'd0: pat = 8'h55;
            2'd1: pat = 8'h66;
            2'd2: pat = 8'hAA;
            2'd3: pat = 8'h99;
            default: pat = 8'h55;
        endcase
        return pat;
    endfunction

endpackage

// ===== rtl/sps_step.sv =====
module sps_step (
    input  sps_pkg::cfg_t         cfg,
    input  sps_pkg::motor_state_t st,
    input  logic                  mode,
    input  logic signed [15:0]    target_angle,
    output sps_pkg::motor_state_t st_next,
    output sps_pkg::result_t      res
);
    import sps_pkg::*;

    logic signed [16:0] diff;
    logic signed [16:0] moved;
    logic               fwd;
    logic               rev;
    logic [1:0]         idx_adv;
    logic [7:0]         pat_new;

    // distance to target and the chosen direction
    assign diff = $signed({target_angle[15], target_angle})
                - $signed({st.shaft_angle[15], st.shaft_angle});
    assign fwd  = diff > STEP_TENTHS;
    assign rev  = diff < -STEP_TENTHS;

    // next table position in the chosen direction
    assign idx_adv = rev ? st.phase_index - 2'd1 : st.phase_index + 2'd1;
    assign pat_new = step_pattern(idx_adv);

    // angle after one finished step, before clamping
    assign moved = st.turn_reverse
                 ? $signed({st.shaft_angle[15], st.shaft_angle}) - STEP_TENTHS
                 : $signed({st.shaft_angle[15], st.shaft_angle}) + STEP_TENTHS;

    // sequencer update
    always_comb begin
        st_next         = st;
        res.delay_start = 1'b0;
        res.delay_ticks = '0;
        case (st.motion_phase)
            PH_IDLE: begin
                if (mode == MODE_POLL && (fwd || rev)) begin
                    st_next.turn_reverse = rev;
                    st_next.phase_index  = idx_adv;
                    res.delay_start      = 1'b1;
                    if (cfg.deadtime_enable) begin
                        // break before make: drop low-nibble bits about to fall
                        st_next.drive_latch  = st.drive_latch
                                             & ~(st.drive_latch & ~pat_new & LOW_NIBBLE);
                        res.delay_ticks      = cfg.deadtime_delay;
                        st_next.motion_phase = PH_DEAD;
                    end else begin
                        st_next.drive_latch  = pat_new;
                        res.delay_ticks      = cfg.step_delay;
                        st_next.motion_phase = PH_STEP;
                    end
                end
            end
            PH_DEAD: begin
                if (mode == MODE_EXPIRY) begin
                    st_next.drive_latch  = step_pattern(st.phase_index);
                    res.delay_start      = 1'b1;
                    res.delay_ticks      = cfg.step_delay;
                    st_next.motion_phase = PH_STEP;
                end
            end
            PH_STEP: begin
                if (mode == MODE_EXPIRY) begin
                    // saturate at the signed 16-bit range
                    case (moved[16:15])
                        2'b01:   st_next.shaft_angle = 16'sh7FFF;
                        2'b10:   st_next.shaft_angle = -16'sh8000;
                        default: st_next.shaft_angle = moved[15:0];
                    endcase
                    st_next.motion_phase = PH_IDLE;
                end
            end
            default: begin
                st_next.motion_phase = PH_IDLE;
            end
        endcase

        // reported fields
        case (st_next.motion_phase)
            PH_DEAD: res.motion_state = STATE_CODE_DEAD;
            PH_STEP: res.motion_state = STATE_CODE_STEP;
            default: res.motion_state = STATE_CODE_IDLE;
        endcase
        res.coil_drive = st_next.drive_latch;
        res.angle_now  = st_next.shaft_angle;
    end

endmodule

// ===== rtl/stepper_phase_sequencer_deadtime.sv =====
// Full-step sequencer for one bipolar stepper channel with optional
// break-before-make. Each request on the s_ side is either a poll carrying a
// target angle in tenths of a degree (tuser 0) or a delay-expiry notice
// (tuser 1); each gives exactly one result on the m_ side with the coil drive
// pattern, a delay request, the motion state and the tracked angle. A request
// passes an input register and is then resolved into the result register;
// one request is taken every cycle while the result side keeps up, and the
// result register holds a finished result while the next request waits in
// the input register. Configuration takes effect at the write edge and
// should only be written while no request is in flight.
module stepper_phase_sequencer_deadtime (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input requests
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sps_pkg::TDATA_IN_W-1:0]     s_tdata,   // [15:0] target_angle
    input  logic                               s_tuser,   // [0] mode
    // results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] coil_drive, [8] delay_start, [24:9] delay_ticks,
    // [26:25] motion_state, [42:27] angle_now, [47:43] zero
    output logic [sps_pkg::TDATA_OUT_W-1:0]    m_tdata,
    // configuration writes
    input  logic                               cfg_wr_en,
    input  logic [1:0]                         cfg_addr,
    input  logic [15:0]                        cfg_wdata
);
    import sps_pkg::*;

    cfg_t         cfg_reg;
    motor_state_t st_reg;
    motor_state_t st_next;
    result_t      res_next;
    result_t      res_reg;

    logic               in_valid_reg;
    logic               in_mode_reg;
    logic signed [15:0] in_target_reg;
    logic               out_valid_reg;
    logic               advance;

    // handshake between input and result registers
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_OUT_W - $bits(result_t)){1'b0}}, res_reg};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.deadtime_enable <= 1'b0;
            cfg_reg.step_delay      <= '0;
            cfg_reg.deadtime_delay  <= DEADTIME_DELAY_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_DEADTIME_ENABLE: cfg_reg.deadtime_enable <= cfg_wdata[0];
                CFG_STEP_DELAY:      cfg_reg.step_delay      <= cfg_wdata;
                CFG_DEADTIME_DELAY:  cfg_reg.deadtime_delay  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg   <= s_tuser;
            in_target_reg <= s_tdata[15:0];
        end
    end

    sps_step u_step (
        .cfg          (cfg_reg),
        .st           (st_reg),
        .mode         (in_mode_reg),
        .target_angle (in_target_reg),
        .st_next      (st_next),
        .res          (res_next)
    );

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase_index  <= 2'd0;
            st_reg.motion_phase <= PH_IDLE;
            st_reg.turn_reverse <= 1'b0;
            st_reg.shaft_angle  <= '0;
            st_reg.drive_latch  <= '0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import sps_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 450;
    localparam int HOLD_CYCLES   = 300;
    localparam int RES_W         = $bits(result_t);

    // full-step coil patterns, entry 0 in the lowest byte
    localparam logic [31:0] COIL_TABLE = 32'h99AA6655;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = MODE_POLL;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [1:0]             cfg_addr  = CFG_DEADTIME_ENABLE;
    logic [15:0]            cfg_wdata = '0;

    // shadow of the sequencer state and its registers
    logic [1:0]         seq_index      = 2'd0;
    logic [1:0]         seq_phase      = STATE_CODE_IDLE;
    logic               seq_reverse    = 1'b0;
    logic signed [15:0] seq_angle      = '0;
    logic [7:0]         seq_latch      = '0;
    logic               sh_deadtime_en = 1'b0;
    logic [15:0]        sh_step_delay  = '0;
    logic [15:0]        sh_dead_delay  = DEADTIME_DELAY_RESET;

    result_t pending_results[$];

    int send_idle_pct   = 0;
    int rcv_stall_pct   = 0;
    int hold_len        = 0;
    int hold_token      = 0;
    int hold_seen       = 0;
    int hold_left       = 0;
    int idle_cycles     = 0;
    int mismatches      = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int coil_steps      = 0;

    stepper_phase_sequencer_deadtime dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // expected result for one request, advancing the shadow state
    function automatic result_t predict_coils(input logic mode,
                                              input logic signed [15:0] target);
        result_t    r;
        int         gap;
        int         moved;
        logic       go;
        logic [7:0] next_pat;
        logic [7:0] falling;
        r  = '0;
        go = 1'b0;
        if (mode == MODE_POLL) begin
            if (seq_phase == STATE_CODE_IDLE) begin
                gap = int'(target) - int'(seq_angle);
                if (gap > int'(STEP_TENTHS)) begin
                    seq_reverse = 1'b0;
                    go = 1'b1;
                end else if (gap < -int'(STEP_TENTHS)) begin
                    seq_reverse = 1'b1;
                    go = 1'b1;
                end
                if (go) begin
                    seq_index = seq_reverse ? seq_index - 2'd1 : seq_index + 2'd1;
                    next_pat = COIL_TABLE[seq_index*8 +: 8];
                    r.delay_start = 1'b1;
                    coil_steps++;
                    if (sh_deadtime_en) begin
                        // break before make: drop low-nibble coils that are about to fall
                        falling = (next_pat ^ seq_latch) & seq_latch & LOW_NIBBLE;
                        seq_latch = seq_latch & ~falling;
                        r.delay_ticks = sh_dead_delay;
                        seq_phase = STATE_CODE_DEAD;
                    end else begin
                        seq_latch = next_pat;
                        r.delay_ticks = sh_step_delay;
                        seq_phase = STATE_CODE_STEP;
                    end
                end
            end
        end else if (seq_phase == STATE_CODE_DEAD) begin
            // pattern already chosen, no second advance
            seq_latch = COIL_TABLE[seq_index*8 +: 8];
            r.delay_start = 1'b1;
            r.delay_ticks = sh_step_delay;
            seq_phase = STATE_CODE_STEP;
        end else if (seq_phase == STATE_CODE_STEP) begin
            moved = seq_reverse ? int'(seq_angle) - int'(STEP_TENTHS)
                                : int'(seq_angle) + int'(STEP_TENTHS);
            if (moved > 32767)
                moved = 32767;
            if (moved < -32768)
                moved = -32768;
            seq_angle = moved[15:0];
            seq_phase = STATE_CODE_IDLE;
        end
        r.coil_drive   = seq_latch;
        r.motion_state = seq_phase;
        r.angle_now    = seq_angle;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0h got %0h at %0t", field, want_v, got_v, $time);
    endtask

    // one request, with a random gap ahead of it
    task automatic send_request(input logic mode, input logic signed [15:0] target);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= target;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_results.push_back(predict_coils(mode, target));
        requests_sent++;
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            CFG_DEADTIME_ENABLE: sh_deadtime_en = value[0];
            CFG_STEP_DELAY:      sh_step_delay  = value;
            CFG_DEADTIME_DELAY:  sh_dead_delay  = value;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly well-formed step sequences, some stray polls and expiries
    task automatic send_motion_item();
        int                 aim;
        logic signed [15:0] target;
        if (seq_phase == STATE_CODE_IDLE) begin
            if ($urandom_range(99) < 15) begin
                send_request(MODE_EXPIRY, 16'($urandom));
            end else begin
                if ($urandom_range(99) < 35) begin
                    target = 16'($urandom);
                end else begin
                    aim = int'(seq_angle) + int'($urandom_range(120)) - 60;
                    if (aim > 32767)
                        aim = 32767;
                    if (aim < -32768)
                        aim = -32768;
                    target = aim[15:0];
                end
                send_request(MODE_POLL, target);
            end
        end else if ($urandom_range(99) < 15) begin
            send_request(MODE_POLL, 16'($urandom));
        end else begin
            send_request(MODE_EXPIRY, 16'($urandom));
        end
    endtask

    task automatic test_directed_cases();
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        write_register(CFG_DEADTIME_ENABLE, 16'd1);
        write_register(CFG_STEP_DELAY, 16'hFFFF);
        write_register(CFG_DEADTIME_DELAY, 16'h0000);
        // expiry with nothing running, then polls just inside one step
        send_request(MODE_EXPIRY, 16'sd0);
        send_request(MODE_POLL, 16'sd18);
        send_request(MODE_POLL, -16'sd18);
        // first move from the all-off latch, with busy polls in between
        send_request(MODE_POLL, 16'sh7FFF);
        send_request(MODE_POLL, 16'sh8000);
        send_request(MODE_EXPIRY, 16'sd0);
        send_request(MODE_POLL, 16'sd0);
        send_request(MODE_EXPIRY, 16'shFFFF);
        // reverse step back through break before make
        send_request(MODE_POLL, 16'sh8000);
        send_request(MODE_EXPIRY, 16'sd0);
        send_request(MODE_EXPIRY, 16'sd0);
        // deadtime switched off while the deadtime phase is running
        send_request(MODE_POLL, 16'sd100);
        wait_results_drained();
        write_register(CFG_DEADTIME_ENABLE, 16'd0);
        send_request(MODE_EXPIRY, 16'sd0);
        send_request(MODE_EXPIRY, 16'sd0);
        // direct steps one tenth past the threshold each way
        send_request(MODE_POLL, 16'sd37);
        send_request(MODE_EXPIRY, 16'sd0);
        send_request(MODE_POLL, 16'sd17);
        send_request(MODE_EXPIRY, 16'sd0);
        wait_results_drained();
    endtask

    task automatic test_random_motion(input int idle_pct, input int stall_pct,
                                      input logic dead_en, input logic [15:0] step_ticks,
                                      input logic [15:0] dead_ticks);
        wait_results_drained();
        write_register(CFG_DEADTIME_ENABLE, {15'd0, dead_en});
        write_register(CFG_STEP_DELAY, step_ticks);
        write_register(CFG_DEADTIME_DELAY, dead_ticks);
        send_idle_pct = idle_pct;
        rcv_stall_pct = stall_pct;
        repeat (PHASE_ITEMS)
            send_motion_item();
    endtask

    // long result hold while requests keep coming, then a full drain
    task automatic test_output_hold();
        wait_results_drained();
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        hold_len = HOLD_CYCLES;
        hold_token++;
        repeat (60)
            send_motion_item();
        wait_results_drained();
    endtask

    // result side ready, with random stalls and the occasional long hold
    always @(posedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= hold_len;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // compare each result with the oldest expectation
    always @(posedge aclk) begin : check_result
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[RES_W-1:0];
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result", '0, 64'(m_tdata));
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.coil_drive !== want.coil_drive)
                    note_mismatch("coil_drive", 64'(want.coil_drive), 64'(got.coil_drive));
                if (got.delay_start !== want.delay_start)
                    note_mismatch("delay_start", 64'(want.delay_start),
                                  64'(got.delay_start));
                if (got.delay_ticks !== want.delay_ticks)
                    note_mismatch("delay_ticks", 64'(want.delay_ticks),
                                  64'(got.delay_ticks));
                if (got.motion_state !== want.motion_state)
                    note_mismatch("motion_state", 64'(want.motion_state),
                                  64'(got.motion_state));
                if (got.angle_now !== want.angle_now)
                    note_mismatch("angle_now", 64'(want.angle_now), 64'(got.angle_now));
                if (m_tdata[TDATA_OUT_W-1:RES_W] !== '0)
                    note_mismatch("padding", '0, 64'(m_tdata[TDATA_OUT_W-1:RES_W]));
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without a handshake", idle_cycles);
            $display("[stepper_phase_sequencer_deadtime] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_random_motion(0, 0, 1'b0, 16'h0000, 16'hFFFF);
        test_random_motion(47, 0, 1'b1, 16'($urandom), 16'($urandom));
        test_output_hold();
        test_random_motion(0, 47, 1'b1, 16'h0001, 16'h8000);
        test_random_motion(35, 35, 1'($urandom), 16'($urandom), 16'($urandom));

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d requests, %0d results checked, %0d coil steps", requests_sent,
                 results_checked, coil_steps);
        $display("deadtime on and off, delay extremes, idle and stall mixes, long output hold");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[stepper_phase_sequencer_deadtime] OK");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches,
                     pending_results.size());
            $display("[stepper_phase_sequencer_deadtime] ERROR");
        end
        $finish;
    end

endmodule
